// ===== sv/tasp_pkg.sv =====
// ----------------------------------------------------------------------------
// tasp_pkg: shared types and codes for the two-axis step pulse generator
// Holds the command and result payload structs and the command mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tasp_pkg;

	localparam logic [1:0] MODE_MOVE   = 2'd0;
	localparam logic [1:0] MODE_TICK_X = 2'd1;
	localparam logic [1:0] MODE_TICK_Y = 2'd2;

	localparam int OUT_POS_BITS = 16;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
		logic               limit_clear_x;
		logic               limit_clear_y;
		logic               request_home;
	} cmd_t;

	typedef struct packed {
		logic               step_x;
		logic               step_y;
		logic               dir_x;
		logic               dir_y;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic               busy_x;
		logic               busy_y;
	} res_t;

endpackage

`default_nettype wire

// ===== sv/tasp_chan_if.sv =====
// ----------------------------------------------------------------------------
// tasp_chan_if: valid/ready channel
// One transfer happens at each rising edge where valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tasp_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/two_axis_step_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// two_axis_step_pulse_generator: step/direction generator for X and Y
// Move commands latch targets and directions; tick commands toggle the step
// level of one axis and commit its position when the pulse count arrives.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload          | meaning
//  --------+-----------+------------------+---------------------------------
//  cmd     | sink      | tasp_pkg::cmd_t  | move command or tick for one axis
//  res     | source    | tasp_pkg::res_t  | axis state after each command
//
// One command is taken every clock while res takes its results. Each command
// goes into an input register (stage one), and the axis update runs from there
// into the result register (stage two), which presents the result on res.
// Reset clears positions, goals, counts, arming and direction, and sets both
// step phases so the next tick raises the step; direction reads reverse.
// When res stalls, the result register holds, stage one keeps one more
// command, and cmd drops ready only once both are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module two_axis_step_pulse_generator #(
	parameter int POS_BITS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	tasp_chan_if.sink    cmd,
	tasp_chan_if.source  res
);

	// Stage one: the accepted command waits here until the result register is free.
	tasp_pkg::cmd_t cmd_s1;
	logic           v_s1;
	// Stage two: the result register presented on res.
	tasp_pkg::res_t res_s2;
	logic           v_s2;

	logic advance;

	// Axis state, index 0 is X and index 1 is Y.
	logic [POS_BITS-1:0] pos_q    [2];
	logic [POS_BITS-1:0] goal_q   [2];
	logic [POS_BITS-1:0] pulses_q [2];
	logic                armed_q  [2];
	logic                fwd_q    [2];
	logic                phase_q  [2];
	logic                home_q;

	logic [POS_BITS-1:0] pos_d    [2];
	logic [POS_BITS-1:0] goal_d   [2];
	logic [POS_BITS-1:0] pulses_d [2];
	logic                armed_d  [2];
	logic                fwd_d    [2];
	logic                phase_d  [2];
	logic                home_d;

	logic [POS_BITS-1:0] tgt       [2];
	logic [POS_BITS-1:0] pulse_inc [2];
	logic [POS_BITS-1:0] distance  [2];
	logic [POS_BITS-1:0] arr_pos   [2];
	logic                hit       [2];
	logic                tick_sel  [2];
	logic                lim_clear [2];

	// The stage-one command moves on whenever the result register is empty
	// or its result is being taken in this cycle.
	assign advance   = v_s1 && (!v_s2 || res.ready);
	assign cmd.ready = !v_s1 || advance;

	assign res.valid = v_s2;
	assign res.data  = res_s2;

	// Targets are sign-extended from 16 bits and wrapped to the position width.
	assign tgt[0] = POS_BITS'(cmd_s1.target_x);
	assign tgt[1] = POS_BITS'(cmd_s1.target_y);

	assign tick_sel[0]  = (cmd_s1.mode == tasp_pkg::MODE_TICK_X);
	assign tick_sel[1]  = (cmd_s1.mode == tasp_pkg::MODE_TICK_Y);
	assign lim_clear[0] = cmd_s1.limit_clear_x;
	assign lim_clear[1] = cmd_s1.limit_clear_y;

	// Per-axis arithmetic for a rising step: the new count, the distance to the
	// goal in the current direction, and the position reached on arrival.
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			pulse_inc[a] = POS_BITS'(pulses_q[a] + 1'b1);
			distance[a]  = fwd_q[a] ? POS_BITS'(goal_q[a] - pos_q[a])
			                        : POS_BITS'(pos_q[a] - goal_q[a]);
			hit[a]       = (pulse_inc[a] >= distance[a]);
			arr_pos[a]   = fwd_q[a] ? POS_BITS'(pos_q[a] + pulse_inc[a])
			                        : POS_BITS'(pos_q[a] - pulse_inc[a]);
		end
	end

	// Next state for the command in stage one. Only one axis ticks per command,
	// so the shared home flag has a single possible consumer each cycle.
	always_comb begin
		home_d = home_q;
		for (int a = 0; a < 2; a++) begin
			pos_d[a]    = pos_q[a];
			goal_d[a]   = goal_q[a];
			pulses_d[a] = pulses_q[a];
			armed_d[a]  = armed_q[a];
			fwd_d[a]    = fwd_q[a];
			phase_d[a]  = phase_q[a];
		end
		unique case (cmd_s1.mode) inside
			tasp_pkg::MODE_MOVE: begin
				for (int a = 0; a < 2; a++) begin
					goal_d[a]  = tgt[a];
					fwd_d[a]   = ($signed(tgt[a]) >= $signed(pos_q[a]));
					armed_d[a] = (tgt[a] != pos_q[a]);
				end
				if (cmd_s1.request_home) begin
					home_d = 1'b1;
				end
			end
			tasp_pkg::MODE_TICK_X, tasp_pkg::MODE_TICK_Y: begin
				for (int a = 0; a < 2; a++) begin
					// Toward the minimum the axis only steps while its limit reads clear.
					if (tick_sel[a] && armed_q[a] && (lim_clear[a] || fwd_q[a])) begin
						if (phase_q[a]) begin
							pulses_d[a] = pulse_inc[a];
							if (hit[a]) begin
								armed_d[a]  = 1'b0;
								pulses_d[a] = '0;
								if (home_q) begin
									pos_d[a] = '0;
									home_d   = 1'b0;
								end else begin
									pos_d[a] = arr_pos[a];
								end
							end
							phase_d[a] = 1'b0;
						end else begin
							phase_d[a] = 1'b1;
						end
					end
				end
			end
			default: begin
				// The unused mode leaves every axis as it is.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			home_q <= 1'b0;
			for (int a = 0; a < 2; a++) begin
				pos_q[a]    <= '0;
				goal_q[a]   <= '0;
				pulses_q[a] <= '0;
				armed_q[a]  <= 1'b0;
				fwd_q[a]    <= 1'b0;
				phase_q[a]  <= 1'b1;
			end
		end else begin
			if (cmd.ready) begin
				v_s1 <= cmd.valid;
			end
			if (advance) begin
				v_s2 <= 1'b1;
			end else if (res.ready) begin
				v_s2 <= 1'b0;
			end
			if (advance) begin
				home_q <= home_d;
				for (int a = 0; a < 2; a++) begin
					pos_q[a]    <= pos_d[a];
					goal_q[a]   <= goal_d[a];
					pulses_q[a] <= pulses_d[a];
					armed_q[a]  <= armed_d[a];
					fwd_q[a]    <= fwd_d[a];
					phase_q[a]  <= phase_d[a];
				end
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= cmd.data;
		end
		if (advance) begin
			res_s2.step_x <= !phase_d[0];
			res_s2.step_y <= !phase_d[1];
			res_s2.dir_x  <= !fwd_d[0];
			res_s2.dir_y  <= !fwd_d[1];
			res_s2.pos_x  <= tasp_pkg::OUT_POS_BITS'($signed(pos_d[0]));
			res_s2.pos_y  <= tasp_pkg::OUT_POS_BITS'($signed(pos_d[1]));
			res_s2.busy_x <= armed_d[0];
			res_s2.busy_y <= armed_d[1];
		end
	end

	// A stalled result must freeze the axis state as well.
	a_stall_freezes_state: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !res.ready) |=> ($stable(pos_q[0]) && $stable(pos_q[1]) &&
		                          $stable(armed_q[0]) && $stable(armed_q[1])))
		else $error("axis state changed while the result was stalled");

	// The home flag is only consumed by an axis that arrives in that cycle.
	a_home_clear_on_arrival: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(home_q) |-> ($fell(armed_q[0]) || $fell(armed_q[1])))
		else $error("home flag cleared without an axis arriving");

	// A new result appears only for a command that sat in stage one.
	a_result_from_stage_one: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(v_s2) |-> $past(v_s1))
		else $error("result register filled without a command in stage one");

endmodule

`default_nettype wire
